// ===== src/rtcl_pkg.sv =====
package rtcl_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int VALUE_BITS_DEF  = 16;
    localparam int NUM_CURVES      = 5;
    localparam int CURVE_BITS      = 3;
    localparam int FIELD_BITS      = 16;

    localparam logic [2:0] CURVE_MASTER = 3'd0;
    localparam logic [2:0] CURVE_RED    = 3'd1;
    localparam logic [2:0] CURVE_GREEN  = 3'd2;
    localparam logic [2:0] CURVE_BLUE   = 3'd3;
    localparam logic [2:0] CURVE_ALPHA  = 3'd4;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    localparam logic [0:0] REG_INPUT_MIN = 1'b0;
    localparam logic [0:0] REG_INPUT_MAX = 1'b1;

    // request from sequencer to the divider
    typedef struct packed {
        logic        start;
        logic [47:0] mag;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [47:0] quot;
    } t_div_rsp;

endpackage

// ===== src/rtcl_div.sv =====
module rtcl_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rtcl_pkg::t_div_req i_req,
    output rtcl_pkg::t_div_rsp o_rsp
);
    import rtcl_pkg::*;

    // restoring divider, one quotient bit per cycle
    logic [47:0] r_num;
    logic [47:0] r_quot;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] n_rem;
    logic [33:0] trial;

    always_comb begin
        n_rem = {r_rem[31:0], r_num[47]};
        trial = {1'b0, n_rem} - {2'b00, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                // rounding: (mag + den/2) / den
                r_num  <= i_req.mag + {17'd0, i_req.den[31:1]};
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_cnt  <= 6'd48;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[46:0], 1'b0};
                if (!trial[33]) begin
                    r_rem  <= trial[32:0];
                    r_quot <= {r_quot[46:0], 1'b1};
                end else begin
                    r_rem  <= n_rem;
                    r_quot <= {r_quot[46:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
endmodule

// ===== src/rgba_tone_curve_lookup.sv =====
// rgba tone curve lookup
// input channel (s_axis): one item is either a table write (tuser = 0) or a
// pixel (tuser = 1). tdata fields from bit 0: curve_select, entry_index,
// entry_x, entry_y, in_red, in_green, in_blue, in_alpha; tlast is entry_last.
// output channel (m_axis): one result item per input item; tuser carries
// is_write_ack (bit 0) and miss_flag (bit 1), tdata the four mapped channels.
// configuration: i_cfg_we / i_cfg_idx / i_cfg_data, register 0 input_min,
// register 1 input_max, to be written only while idle (not enforced by the block).
// a write result is presented from S_OUT after one pass through S_WRITE. A pixel
// runs seven curve lookups in turn through one table read port and one serial
// divider: each lookup reads entry 0 and, unless clamped low, the last entry,
// then searches the intervals (one table read per entry) and divides when it
// interpolates. the next item is taken the cycle after the result is taken.
// one item is in work at a time; s_axis_tready is low from acceptance until
// the result has been taken, so a stalled receiver simply holds the result.
// reset clears the last-entry marks and the sequencer and sets input_min to 0
// and input_max to 4096; the table itself is undefined until written.
module rgba_tone_curve_lookup #(
    parameter int TABLE_DEPTH = rtcl_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_BITS  = rtcl_pkg::VALUE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // curve_select[2:0], entry_index[10:3], entry_x[26:11], entry_y[42:27],
    // in_red[58:43], in_green[74:59], in_blue[90:75], in_alpha[106:91],
    // zero pad
    input  logic [111:0] s_axis_tdata,
    // req_type
    input  logic         s_axis_tuser,
    // entry_last
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [63:0]  m_axis_tdata,
    // is_write_ack, miss_flag
    output logic [1:0]   m_axis_tuser
);
    import rtcl_pkg::*;

    localparam int IDX_BITS = $clog2(TABLE_DEPTH);
    localparam int MEM_DEPTH = NUM_CURVES * TABLE_DEPTH;
    localparam int ADDR_BITS = $clog2(MEM_DEPTH);
    localparam logic signed [47:0] SAT_HI = (48'sd1 <<< (VALUE_BITS - 1)) - 48'sd1;
    localparam logic signed [47:0] SAT_LO = -SAT_HI - 48'sd1;

    typedef enum logic [3:0] {
        S_IDLE, S_WRITE, S_START, S_RD0, S_RDLAST, S_SRCH_A, S_SRCH_B,
        S_CHECK, S_MUL, S_DIV, S_DONE, S_OUT
    } t_state;

    t_state r_state;
    logic signed [15:0] r_min, r_max;
    logic [7:0] r_last [NUM_CURVES];
    logic [31:0] mem [MEM_DEPTH];
    logic [31:0] r_rd;
    logic [ADDR_BITS-1:0] r_addr;
    logic r_rd_en;
    logic [106:0] r_in;
    logic r_in_last;
    logic r_type;
    logic [2:0] r_step;
    logic signed [15:0] r_v;
    logic [IDX_BITS-1:0] r_i, r_lim;
    logic signed [15:0] r_x0, r_y0, r_x1, r_y1;
    logic signed [47:0] r_prod;
    logic r_miss;
    logic signed [15:0] r_res [4];
    logic [1:0] r_phase;
    t_div_req div_req;
    t_div_rsp div_rsp;

    rtcl_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    // step order: master r, red, master g, green, master b, blue, alpha
    logic [2:0] cur_curve;
    logic signed [15:0] step_in;
    always_comb begin
        case (r_step)
            3'd0: begin cur_curve = CURVE_MASTER; step_in = r_in[58:43]; end
            3'd1: begin cur_curve = CURVE_RED;    step_in = r_v; end
            3'd2: begin cur_curve = CURVE_MASTER; step_in = r_in[74:59]; end
            3'd3: begin cur_curve = CURVE_GREEN;  step_in = r_v; end
            3'd4: begin cur_curve = CURVE_MASTER; step_in = r_in[90:75]; end
            3'd5: begin cur_curve = CURVE_BLUE;   step_in = r_v; end
            default: begin cur_curve = CURVE_ALPHA; step_in = r_in[106:91]; end
        endcase
    end

    logic [IDX_BITS-1:0] last_lim;
    always_comb begin
        if ({24'd0, r_last[cur_curve]} >= 32'(TABLE_DEPTH))
            last_lim = IDX_BITS'(TABLE_DEPTH - 1);
        else
            last_lim = IDX_BITS'(r_last[cur_curve]);
    end

    function automatic logic [ADDR_BITS-1:0] addr_of(logic [2:0] c, logic [IDX_BITS-1:0] i);
        return ADDR_BITS'(c) * ADDR_BITS'(TABLE_DEPTH) + ADDR_BITS'(i);
    endfunction

    // table memory, one write port and one read port
    logic w_en;
    logic [ADDR_BITS-1:0] w_addr;
    always_ff @(posedge i_clk) begin
        if (w_en) mem[w_addr] <= {r_in[26:11], r_in[42:27]};
        if (r_rd_en) r_rd <= mem[r_addr];
    end

    logic wr_ok;
    assign wr_ok = (r_in[2:0] <= CURVE_ALPHA) && ({24'd0, r_in[10:3]} < 32'(TABLE_DEPTH));
    assign w_en = (r_state == S_WRITE) && wr_ok;
    assign w_addr = addr_of(r_in[2:0], IDX_BITS'(r_in[10:3]));

    logic signed [16:0] dx;
    logic signed [47:0] sum;
    assign dx = 17'(r_x1) - 17'(r_x0);
    assign sum = 48'(r_y0) + (r_prod[47] ? -$signed(div_rsp.quot) : $signed(div_rsp.quot));

    always_comb begin
        div_req.start = (r_state == S_MUL);
        div_req.mag = r_prod[47] ? 48'(-r_prod) : 48'(r_prod);
        div_req.den = 32'(dx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_min <= 16'sd0;
            r_max <= 16'sd4096;
            for (int k = 0; k < NUM_CURVES; k++) r_last[k] <= 8'd0;
            r_rd_en <= 1'b0;
            r_phase <= '0;
        end else begin
            r_rd_en <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_INPUT_MIN: r_min <= i_cfg_data;
                    REG_INPUT_MAX: r_max <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_in <= s_axis_tdata[106:0];
                    r_in_last <= s_axis_tlast;
                    r_type <= s_axis_tuser;
                    r_step <= 3'd0;
                    r_miss <= 1'b0;
                    r_state <= (s_axis_tuser == REQ_WRITE) ? S_WRITE : S_START;
                end
                S_WRITE: begin
                    if (wr_ok && r_in_last) r_last[r_in[2:0]] <= r_in[10:3];
                    for (int k = 0; k < 4; k++) r_res[k] <= 16'sd0;
                    r_state <= S_OUT;
                end
                S_START: begin
                    r_v <= step_in;
                    r_lim <= last_lim;
                    r_i <= '0;
                    r_addr <= addr_of(cur_curve, '0);
                    r_rd_en <= 1'b1;
                    r_phase <= 2'd0;
                    r_state <= S_RD0;
                end
                S_RD0: begin
                    // wait for read of entry 0
                    if (r_phase == 2'd1) begin
                        r_x0 <= r_rd[31:16];
                        r_y0 <= r_rd[15:0];
                        if (r_v <= r_min) begin
                            r_v <= r_rd[15:0];
                            r_state <= S_DONE;
                        end else begin
                            r_addr <= addr_of(cur_curve, r_lim);
                            r_rd_en <= 1'b1;
                            r_phase <= 2'd0;
                            r_state <= S_RDLAST;
                        end
                    end else r_phase <= r_phase + 2'd1;
                end
                S_RDLAST: begin
                    if (r_phase == 2'd1) begin
                        if (r_v >= r_max) begin
                            r_v <= r_rd[15:0];
                            r_state <= S_DONE;
                        end else if (r_lim == '0) begin
                            r_miss <= 1'b1;
                            r_v <= 16'sd0;
                            r_state <= S_DONE;
                        end else begin
                            r_addr <= addr_of(cur_curve, r_i + 1'b1);
                            r_rd_en <= 1'b1;
                            r_phase <= 2'd0;
                            r_state <= S_SRCH_A;
                        end
                    end else r_phase <= r_phase + 2'd1;
                end
                S_SRCH_A: begin
                    if (r_phase == 2'd1) begin
                        r_x1 <= r_rd[31:16];
                        r_y1 <= r_rd[15:0];
                        r_state <= S_CHECK;
                    end else r_phase <= r_phase + 2'd1;
                end
                S_CHECK: begin
                    if (r_x0 <= r_v && r_v <= r_x1) begin
                        if (r_x0 == r_x1) begin
                            r_v <= r_y0;
                            r_state <= S_DONE;
                        end else begin
                            r_prod <= 48'(17'(r_v) - 17'(r_x0)) * 48'(17'(r_y1) - 17'(r_y0));
                            r_state <= S_MUL;
                        end
                    end else if (r_i + 1'b1 == r_lim) begin
                        r_miss <= 1'b1;
                        r_v <= 16'sd0;
                        r_state <= S_DONE;
                    end else begin
                        r_x0 <= r_x1;
                        r_y0 <= r_y1;
                        r_i <= r_i + 1'b1;
                        r_addr <= addr_of(cur_curve, r_i + IDX_BITS'(2));
                        r_rd_en <= 1'b1;
                        r_phase <= 2'd0;
                        r_state <= S_SRCH_B;
                    end
                end
                S_SRCH_B: begin
                    if (r_phase == 2'd1) begin
                        r_x1 <= r_rd[31:16];
                        r_y1 <= r_rd[15:0];
                        r_state <= S_CHECK;
                    end else r_phase <= r_phase + 2'd1;
                end
                S_MUL: r_state <= S_DIV;
                S_DIV: if (div_rsp.done) begin
                    if (sum > SAT_HI) r_v <= 16'(SAT_HI);
                    else if (sum < SAT_LO) r_v <= 16'(SAT_LO);
                    else r_v <= 16'(sum);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    case (r_step)
                        3'd1: r_res[0] <= r_v;
                        3'd3: r_res[1] <= r_v;
                        3'd5: r_res[2] <= r_v;
                        3'd6: r_res[3] <= r_v;
                        default: ;
                    endcase
                    if (r_step == 3'd6) r_state <= S_OUT;
                    else begin
                        r_step <= r_step + 3'd1;
                        r_state <= S_START;
                    end
                end
                S_OUT: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata = {r_res[3], r_res[2], r_res[1], r_res[0]};
    assign m_axis_tuser = {r_type == REQ_PIXEL ? r_miss : 1'b0, r_type == REQ_WRITE};

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
    a_ack_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 64'd0 && !m_axis_tuser[1])
        else $error("write ack carries data");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
`endif
endmodule

// ===== tb/rgba_tone_curve_lookup_tb.sv =====
`timescale 1ns / 1ps

module rgba_tone_curve_lookup_tb;
    import rtcl_pkg::*;

    localparam int DEPTH     = TABLE_DEPTH_DEF;
    localparam int MAX_CYCLE = 3000000;
    localparam int TAIL_WAIT = 60;

    // one input item: a table write or a pixel
    typedef struct {
        logic               req;
        logic [2:0]         curve;
        logic [7:0]         idx;
        logic               last;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] r;
        logic signed [15:0] g;
        logic signed [15:0] b;
        logic signed [15:0] a;
    } t_tone_item;

    // one result item
    typedef struct {
        logic signed [15:0] r;
        logic signed [15:0] g;
        logic signed [15:0] b;
        logic signed [15:0] a;
        logic               ack;
        logic               miss;
    } t_tone_result;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [0:0]   i_cfg_idx;
    logic [15:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // curve_select, entry_index, entry_x, entry_y, in_red, in_green,
    // in_blue, in_alpha, zero pad
    logic [111:0] s_axis_tdata;
    // req_type
    logic         s_axis_tuser;
    // entry_last
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // out_red, out_green, out_blue, out_alpha
    logic [63:0]  m_axis_tdata;
    // is_write_ack, miss_flag
    logic [1:0]   m_axis_tuser;

    rgba_tone_curve_lookup dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // queues: items waiting to be driven, results still owed by the block
    t_tone_item   item_q[$];
    t_tone_result owed_q[$];
    t_tone_item   cur_item;

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_cnt = 0;
    int cycle_cnt = 0;

    // predictor copy of the curves and limits
    logic signed [15:0] tab_x[NUM_CURVES][DEPTH];
    logic signed [15:0] tab_y[NUM_CURVES][DEPTH];
    int                 last_mark[NUM_CURVES];
    logic signed [15:0] lim_min;
    logic signed [15:0] lim_max;

    // generator's own record of what has been written, so that no pixel ever
    // reads an entry that was never loaded
    bit gen_written[NUM_CURVES][DEPTH];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // one curve lookup: clamp, linear search, rounded interpolation
    function automatic logic signed [15:0] curve_map(logic [2:0] c, logic signed [15:0] v,
                                                      inout bit miss);
        int                 lst;
        longint             x0, x1, y0, y1, num, den, q;
        longint unsigned    mag;
        lst = last_mark[c];
        if (v <= lim_min) return tab_y[c][0];
        if (v >= lim_max) return tab_y[c][lst];
        for (int i = 0; i < lst; i++) begin
            x0 = longint'(tab_x[c][i]);
            x1 = longint'(tab_x[c][i+1]);
            if (x0 <= v && v <= x1) begin
                y0 = longint'(tab_y[c][i]);
                y1 = longint'(tab_y[c][i+1]);
                den = x1 - x0;
                if (den == 0) return tab_y[c][i];
                num = (longint'(v) - x0) * (y1 - y0);
                mag = (num < 0) ? -num : num;
                mag = (mag + den / 2) / den;
                q = y0 + ((num < 0) ? -longint'(mag) : longint'(mag));
                if (q > 32767) q = 32767;
                if (q < -32768) q = -32768;
                return q[15:0];
            end
        end
        miss = 1'b1;
        return '0;
    endfunction

    // apply one accepted item and queue the result it should cause
    function automatic void predict_item(t_tone_item it);
        t_tone_result res;
        bit           miss;
        res = '{default: '0};
        miss = 1'b0;
        if (it.req == REQ_WRITE) begin
            if (it.curve < NUM_CURVES) begin
                tab_x[it.curve][it.idx] = it.x;
                tab_y[it.curve][it.idx] = it.y;
                if (it.last) last_mark[it.curve] = int'(it.idx);
            end
            res.ack = 1'b1;
        end else begin
            res.r = curve_map(CURVE_RED,   curve_map(CURVE_MASTER, it.r, miss), miss);
            res.g = curve_map(CURVE_GREEN, curve_map(CURVE_MASTER, it.g, miss), miss);
            res.b = curve_map(CURVE_BLUE,  curve_map(CURVE_MASTER, it.b, miss), miss);
            res.a = curve_map(CURVE_ALPHA, it.a, miss);
            res.miss = miss;
        end
        owed_q = {owed_q, res};
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= REQ_WRITE;
            s_axis_tlast  <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_item(cur_item);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (item_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_item = item_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= cur_item.req;
                    s_axis_tlast  <= cur_item.last;
                    s_axis_tdata  <= {5'b0, cur_item.a, cur_item.b, cur_item.g,
                                      cur_item.r, cur_item.y, cur_item.x,
                                      cur_item.idx, cur_item.curve};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic note_bad(string fname, logic [15:0] want, logic [15:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch %s: expected %h, got %h", fname, want, got);
    endtask

    // monitor
    always @(posedge i_clk) begin
        t_tone_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (owed_q.size() == 0) begin
                    note_bad("unexpected result", '0, m_axis_tdata[15:0]);
                end else begin
                    want = owed_q.pop_front();
                    if (m_axis_tdata[15:0] !== want.r) note_bad("out_red", want.r,
                                                                 m_axis_tdata[15:0]);
                    if (m_axis_tdata[31:16] !== want.g) note_bad("out_green", want.g,
                                                                  m_axis_tdata[31:16]);
                    if (m_axis_tdata[47:32] !== want.b) note_bad("out_blue", want.b,
                                                                  m_axis_tdata[47:32]);
                    if (m_axis_tdata[63:48] !== want.a) note_bad("out_alpha", want.a,
                                                                  m_axis_tdata[63:48]);
                    if (m_axis_tuser[0] !== want.ack) note_bad("is_write_ack", 16'(want.ack),
                                                                16'(m_axis_tuser[0]));
                    if (m_axis_tuser[1] !== want.miss) note_bad("miss_flag", 16'(want.miss),
                                                                 16'(m_axis_tuser[1]));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= MAX_CYCLE) begin
            $display("rgba_tone_curve_lookup_tb: done, errors");
            $finish;
        end
    end

    // stimulus helpers
    task automatic push_write(logic [2:0] c, logic [7:0] ix, logic lst,
                              logic signed [15:0] px, logic signed [15:0] py);
        t_tone_item it;
        it = '{default: '0};
        it.req = REQ_WRITE;
        it.curve = c;
        it.idx = ix;
        it.last = lst;
        it.x = px;
        it.y = py;
        // garbage in the pixel fields of a write
        it.r = 16'($urandom);
        it.a = 16'($urandom);
        if (c < NUM_CURVES) gen_written[c][ix] = 1'b1;
        item_q = {item_q, it};
    endtask

    task automatic push_pixel(logic signed [15:0] pr, logic signed [15:0] pg,
                              logic signed [15:0] pb, logic signed [15:0] pa);
        t_tone_item it;
        it = '{default: '0};
        it.req = REQ_PIXEL;
        it.curve = 3'($urandom);
        it.idx = 8'($urandom);
        it.last = 1'($urandom);
        it.x = 16'($urandom);
        it.y = 16'($urandom);
        it.r = pr;
        it.g = pg;
        it.b = pb;
        it.a = pa;
        item_q = {item_q, it};
    endtask

    // loads entries 0..n-1 of a curve, marking the last; x ascending unless
    // scrambled, with repeated x now and then for zero-width intervals
    task automatic load_curve(int c, int n, bit scrambled);
        int x_now;
        x_now = $urandom_range(0, 12000) - 10000;
        if ($urandom_range(9) == 0) x_now = -32768;
        for (int i = 0; i < n; i++) begin
            if (scrambled) x_now = $urandom_range(0, 65535) - 32768;
            push_write(3'(c), 8'(i), i == n - 1, x_now[15:0], 16'($urandom));
            x_now += ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 4000);
            if (x_now > 32767) x_now = 32767;
        end
    endtask

    function automatic logic signed [15:0] pick_value();
        int v;
        if ($urandom_range(3) == 0) return 16'($urandom);
        v = $urandom_range(0, 20000) - 8000;
        if ($urandom_range(7) == 0) v = int'(lim_min) + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(7) == 0) v = int'(lim_max) + int'($urandom_range(0, 2)) - 1;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    task automatic push_noise();
        int c;
        int ix;
        c = $urandom_range(0, NUM_CURVES - 1);
        ix = $urandom_range(0, DEPTH - 1);
        case ($urandom_range(2))
            0: push_write(3'($urandom_range(NUM_CURVES, 7)), 8'($urandom), 1'($urandom),
                          16'($urandom), 16'($urandom));
            1: push_write(3'(c), 8'(ix), 1'b0, 16'($urandom), 16'($urandom));
            default: begin
                // move the last mark only onto an index with all below it loaded
                ix = $urandom_range(0, 20);
                for (int i = 0; i <= ix; i++)
                    if (!gen_written[c][i]) ix = -1;
                if (ix >= 0) push_write(3'(c), 8'(ix), 1'b1, 16'($urandom), 16'($urandom));
                else push_write(3'(c), 8'($urandom_range(0, DEPTH - 1)), 1'b0,
                                16'($urandom), 16'($urandom));
            end
        endcase
    endtask

    task automatic wait_drained();
        while (item_q.size() > 0 || s_axis_tvalid || owed_q.size() > 0)
            @(posedge i_clk);
    endtask

    // both limits written back to back while the block is idle
    task automatic set_limits(logic signed [15:0] lo, logic signed [15:0] hi);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_INPUT_MIN;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_idx  <= REG_INPUT_MAX;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        lim_min = lo;
        lim_max = hi;
    endtask

    task automatic random_phase(int n_items);
        int start;
        int c;
        start = item_q.size();
        while (item_q.size() - start < n_items) begin
            case ($urandom_range(9))
                0, 1: begin
                    c = $urandom_range(0, NUM_CURVES - 1);
                    load_curve(c, ($urandom_range(15) == 0) ? 32 : $urandom_range(2, 8),
                               $urandom_range(6) == 0);
                end
                2: push_noise();
                default: push_pixel(pick_value(), pick_value(), pick_value(),
                                    pick_value());
            endcase
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_INPUT_MIN;
        i_cfg_data    = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        lim_min = 16'sd0;
        lim_max = 16'sd4096;
        for (int c = 0; c < NUM_CURVES; c++) last_mark[c] = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset limits, hand-built curves
        set_limits(16'sd0, 16'sd4096);
        // master with a zero-width interval at 2048
        push_write(CURVE_MASTER, 8'd0, 1'b0, 16'sd0,    16'sd0);
        push_write(CURVE_MASTER, 8'd1, 1'b0, 16'sd2048, 16'sd1000);
        push_write(CURVE_MASTER, 8'd2, 1'b0, 16'sd2048, 16'sd3000);
        push_write(CURVE_MASTER, 8'd3, 1'b1, 16'sd4096, 16'sd4096);
        // red leaves a gap below 100, so small values miss
        push_write(CURVE_RED,   8'd0, 1'b0, 16'sd100,  -16'sd32768);
        push_write(CURVE_RED,   8'd1, 1'b1, 16'sd3000, 16'sd32767);
        push_write(CURVE_GREEN, 8'd0, 1'b0, 16'sd0,    16'sd4096);
        push_write(CURVE_GREEN, 8'd1, 1'b1, 16'sd4096, 16'sd0);
        push_write(CURVE_BLUE,  8'd0, 1'b0, -16'sd32768, 16'sd32767);
        push_write(CURVE_BLUE,  8'd1, 1'b1, 16'sd32767,  -16'sd32768);
        // alpha stops at 4000, so 4001..4095 misses
        push_write(CURVE_ALPHA, 8'd0, 1'b0, 16'sd0,    16'sd0);
        push_write(CURVE_ALPHA, 8'd1, 1'b1, 16'sd4000, 16'sd4096);
        // bad curve select (acknowledged only) and a write to the top index of red
        push_write(3'd7, 8'd255, 1'b1, 16'sd1, 16'sd1);
        push_write(CURVE_RED, 8'd255, 1'b0, -16'sd1, -16'sd1);
        push_pixel(-16'sd32768, 16'sd32767, 16'sd0, 16'sd4096);
        push_pixel(16'sd2048, 16'sd2048, 16'sd2048, 16'sd4050);
        push_pixel(16'sd50, 16'sd1, 16'sd4095, 16'sd3999);
        push_pixel(16'sd1234, 16'sd3333, 16'sd777, 16'sd1);
        push_pixel(16'sd32767, -16'sd32768, 16'sd1024, -16'sd1);
        push_pixel(16'sd2047, 16'sd2049, 16'sd3000, 16'sd2000);
        wait_drained();

        // phase 1: widest limits, no idling
        set_limits(-16'sd32768, 16'sd32767);
        random_phase(65);
        wait_drained();

        // phase 2: sender idle most of the time; paused once until all results are in
        send_idle_pct = 61;
        set_limits(-16'sd4096, 16'sd8192);
        random_phase(33);
        wait_drained();
        random_phase(33);
        wait_drained();

        // phase 3: receiver stalling, limits first reversed so everything clamps low, then random
        send_idle_pct  = 0;
        recv_stall_pct = 61;
        set_limits(16'sd32767, -16'sd32768);
        random_phase(20);
        wait_drained();
        set_limits(16'($urandom_range(0, 4000) - 2000), 16'($urandom_range(2000, 12000)));
        random_phase(45);
        wait_drained();

        // phase 4: both sides idling a little
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        set_limits(16'sd0, 16'sd4096);
        random_phase(65);
        wait_drained();

        repeat (TAIL_WAIT) @(posedge i_clk);
        if (mismatch_cnt == 0 && owed_q.size() == 0) begin
            $display("rgba_tone_curve_lookup_tb: done, clean");
        end else begin
            $display("rgba_tone_curve_lookup_tb: done, errors");
        end
        $finish;
    end

endmodule
